// ===== hw/rtl/idlru_pkg.sv =====
// Shared types and codes for the idle connection LRU timeout block.
`timescale 1ns / 1ps

package idlru_pkg;

	localparam int ID_W = 5;
	localparam int LIMIT_W = 32;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd10000000;

	typedef enum logic [1:0] {
		REQ_OPEN  = 2'd0,
		REQ_CLOSE = 2'd1,
		REQ_ACT   = 2'd2,
		REQ_TICK  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		K_DONE     = 2'd0,
		K_SHUTDOWN = 2'd1,
		K_ALREADY  = 2'd2,
		K_NOT_OPEN = 2'd3
	} kind_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LRD  = 7'b0000010,
		ST_UNL2 = 7'b0000100,
		ST_APP1 = 7'b0001000,
		ST_APP2 = 7'b0010000,
		ST_TICK = 7'b0100000,
		ST_TEND = 7'b1000000
	} state_t;

endpackage

// ===== hw/rtl/idle_connection_lru_timeout.sv =====
// Top level: LRU-ordered idle connection list with timeout walk.
// Open/close/activity: one result word the cycle after start; stays busy through the
//   link memory read, up to two single-field link writes and append (rejects stay idle).
// Tick: walks one list entry per cycle through the time and link memories;
//   busy for the walk and its end state, not busy at all on an empty list;
//   results trail the walk, with last set on the final one.
// Results cannot be stalled; each is shown for exactly one cycle.
// Reset: all slots closed, list empty, limit 10000000 us; memories are not cleared.
`timescale 1ns / 1ps

module idle_connection_lru_timeout
	import idlru_pkg::*;
#(
	parameter int MAX_CONN = 32,
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [ID_W-1:0]      conn_id,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LIMIT_W-1:0]   cfg_data,
	output logic                 res_valid,
	output logic [ID_W-1:0]      conn_id_res,
	output logic [1:0]           result_kind,
	output logic                 last
);

	localparam int IW = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
	localparam int TW = TIME_BITS;

	typedef struct packed {
		logic [IW-1:0] nxt;
		logic [IW-1:0] prv;
	} link_t;

	function automatic logic [IW-1:0] safe_idx(input logic [IW-1:0] x);
		return (int'(x) < MAX_CONN) ? x : '0;
	endfunction

	// memories
	logic [TW-1:0] tmem [MAX_CONN];
	link_t         lmem [MAX_CONN];

	state_t state_q, state_d;
	req_t   req_q, req_d;
	logic [IW-1:0] id_q, id_d, cur_q, cur_d, step_q, step_d;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d, pend_q, pend_d, pp_q, pp_d, pn_q, pn_d;
	logic          empty_q, empty_d, pend_v_q, pend_v_d;
	logic [TW-1:0] now_q, now_d;
	logic [LIMIT_W-1:0] idle_limit_q;
	logic [MAX_CONN-1:0] open_q, open_d, closing_q, closing_d;

	logic          res_valid_q, out_set;
	logic [ID_W-1:0] res_id_q, out_id;
	kind_t         res_kind_q, out_kind;
	logic          res_last_q, out_last;

	logic          tm_we;
	logic [IW-1:0] tm_wa;
	logic [TW-1:0] tm_wd;
	logic          lw_en_n, lw_en_p;
	logic [IW-1:0] lw_addr, lw_data, rd_addr;
	logic [TW-1:0] tm_rd_q;
	link_t         lm_rd_q;

	logic [IW-1:0] in_idx;
	logic          in_ok;
	logic [TW-1:0] age;
	logic          is_idle, is_jump;

	assign in_idx = IW'(conn_id);
	assign in_ok = int'(conn_id) < MAX_CONN;
	assign age = now_q - tm_rd_q;
	assign is_jump = now_q < tm_rd_q;
	assign is_idle = !is_jump && (age > TW'(idle_limit_q));

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign conn_id_res = res_id_q;
	assign result_kind = res_kind_q;
	assign last = res_last_q;

	always_ff @(posedge clk) begin
		if (tm_we)
			tmem[tm_wa] <= tm_wd;
		if (lw_en_n)
			lmem[lw_addr].nxt <= lw_data;
		if (lw_en_p)
			lmem[lw_addr].prv <= lw_data;
		tm_rd_q <= tmem[rd_addr];
		lm_rd_q <= lmem[rd_addr];
	end

	always_comb begin
		logic [IW-1:0] p;
		logic [IW-1:0] n;
		logic          stop;
		state_d = state_q;
		req_d = req_q;
		id_d = id_q;
		now_d = now_q;
		cur_d = cur_q;
		step_d = step_q;
		head_d = head_q;
		tail_d = tail_q;
		empty_d = empty_q;
		pend_d = pend_q;
		pend_v_d = pend_v_q;
		pp_d = pp_q;
		pn_d = pn_q;
		open_d = open_q;
		closing_d = closing_q;
		tm_we = 1'b0;
		tm_wa = id_q;
		tm_wd = now_q;
		lw_en_n = 1'b0;
		lw_en_p = 1'b0;
		lw_addr = id_q;
		lw_data = id_q;
		rd_addr = cur_q;
		out_set = 1'b0;
		out_id = '0;
		out_kind = K_DONE;
		out_last = 1'b1;
		p = safe_idx(lm_rd_q.prv);
		n = safe_idx(lm_rd_q.nxt);
		stop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_d = req_t'(req_type);
					id_d = in_idx;
					now_d = event_time;
					if (req_t'(req_type) == REQ_TICK) begin
						if (empty_q) begin
							out_set = 1'b1;
						end else begin
							cur_d = head_q;
							rd_addr = head_q;
							step_d = '0;
							pend_v_d = 1'b0;
							state_d = ST_TICK;
						end
					end else if (!in_ok) begin
						out_set = 1'b1;
						out_id = conn_id;
						out_kind = K_NOT_OPEN;
					end else if (req_t'(req_type) == REQ_OPEN) begin
						out_set = 1'b1;
						out_id = conn_id;
						if (open_q[in_idx]) begin
							out_kind = K_ALREADY;
						end else begin
							open_d[in_idx] = 1'b1;
							closing_d[in_idx] = 1'b0;
							tm_we = 1'b1;
							tm_wa = in_idx;
							tm_wd = event_time;
							state_d = ST_APP1;
						end
					end else if (!open_q[in_idx]) begin
						out_set = 1'b1;
						out_id = conn_id;
						out_kind = K_NOT_OPEN;
					end else begin
						out_set = 1'b1;
						out_id = conn_id;
						rd_addr = in_idx;
						state_d = ST_LRD;
					end
				end
			end
			ST_LRD: begin
				pp_d = p;
				pn_d = n;
				state_d = (req_q == REQ_CLOSE) ? ST_IDLE : ST_APP1;
				if (head_q == id_q && tail_q == id_q) begin
					empty_d = 1'b1;
					head_d = '0;
					tail_d = '0;
				end else if (head_q == id_q) begin
					head_d = n;
				end else if (tail_q == id_q) begin
					tail_d = p;
				end else begin
					lw_en_n = 1'b1;
					lw_addr = p;
					lw_data = n;
					state_d = ST_UNL2;
				end
				if (req_q == REQ_CLOSE) begin
					open_d[id_q] = 1'b0;
					closing_d[id_q] = 1'b0;
				end else begin
					tm_we = 1'b1;
				end
			end
			ST_UNL2: begin
				lw_en_p = 1'b1;
				lw_addr = pn_q;
				lw_data = pp_q;
				state_d = (req_q == REQ_CLOSE) ? ST_IDLE : ST_APP1;
			end
			ST_APP1: begin
				if (empty_q) begin
					head_d = id_q;
					tail_d = id_q;
					empty_d = 1'b0;
					state_d = ST_IDLE;
				end else begin
					lw_en_n = 1'b1;
					lw_addr = tail_q;
					lw_data = id_q;
					state_d = ST_APP2;
				end
			end
			ST_APP2: begin
				lw_en_p = 1'b1;
				lw_addr = id_q;
				lw_data = tail_q;
				tail_d = id_q;
				state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (is_idle && !closing_q[cur_q]) begin
					closing_d[cur_q] = 1'b1;
					pend_d = cur_q;
					pend_v_d = 1'b1;
					if (pend_v_q) begin
						out_set = 1'b1;
						out_id = ID_W'(pend_q);
						out_kind = K_SHUTDOWN;
						out_last = 1'b0;
					end
				end
				if (is_jump) begin
					tm_we = 1'b1;
					tm_wa = cur_q;
				end
				stop = !(is_idle || is_jump) || (cur_q == tail_q)
					|| (step_q == IW'(MAX_CONN - 1));
				if (stop) begin
					state_d = ST_TEND;
				end else begin
					cur_d = n;
					rd_addr = n;
					step_d = step_q + IW'(1);
				end
			end
			ST_TEND: begin
				out_set = 1'b1;
				if (pend_v_q) begin
					out_id = ID_W'(pend_q);
					out_kind = K_SHUTDOWN;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q <= '0;
			closing_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			pend_v_q <= 1'b0;
			idle_limit_q <= LIMIT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			open_q <= open_d;
			closing_q <= closing_d;
			head_q <= head_d;
			tail_q <= tail_d;
			empty_q <= empty_d;
			pend_v_q <= pend_v_d;
			if (cfg_valid && cfg_ready)
				idle_limit_q <= cfg_data;
			res_valid_q <= out_set;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		id_q <= id_d;
		now_q <= now_d;
		cur_q <= cur_d;
		step_q <= step_d;
		pend_q <= pend_d;
		pp_q <= pp_d;
		pn_q <= pn_d;
		res_id_q <= out_id;
		res_kind_q <= out_kind;
		res_last_q <= out_last;
	end

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type != REQ_TICK |=> res_valid && last)
		else $error("connection command gave no single result");

	a_tick_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEND |=> res_valid && last)
		else $error("tick walk ended without final result");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> head_q == '0 && tail_q == '0)
		else $error("empty list with nonzero head or tail");

	a_closing_open: assert property (@(posedge clk) disable iff (!arst_n)
		(closing_q & ~open_q) == '0)
		else $error("closing flag on a slot that is not open");

endmodule

// ===== bench/idle_connection_lru_timeout_tb.sv =====
// Testbench for the idle connection LRU timeout block: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module idle_connection_lru_timeout_tb;
	import idlru_pkg::*;

	typedef struct {
		logic [ID_W-1:0] id;
		kind_t           kind;
		logic            lst;
	} word_t;

	// Tracks the slot list and the expected result words.
	class conn_tracker;
		logic [LIMIT_W-1:0] idle_limit;
		bit                 is_open [32];
		bit                 closing [32];
		logic [47:0]        stamp [32];
		logic [ID_W-1:0]    nxt [32];
		logic [ID_W-1:0]    prv [32];
		logic [ID_W-1:0]    head;
		logic [ID_W-1:0]    tail;
		bit                 is_empty;
		word_t              pending_words[$];
		int                 faults;

		function new();
			idle_limit = LIMIT_RESET;
			for (int i = 0; i < 32; i++) begin
				is_open[i] = 0;
				closing[i] = 0;
				stamp[i] = '0;
				nxt[i] = '0;
				prv[i] = '0;
			end
			head = '0;
			tail = '0;
			is_empty = 1;
			faults = 0;
		endfunction

		function void push_word(logic [ID_W-1:0] id, kind_t kind, logic lst);
			word_t w;
			w.id = id;
			w.kind = kind;
			w.lst = lst;
			pending_words = {pending_words, w};
		endfunction

		function void unlink(logic [ID_W-1:0] s);
			logic [ID_W-1:0] p;
			logic [ID_W-1:0] n;
			p = prv[s];
			n = nxt[s];
			if (head == s && tail == s) begin
				is_empty = 1;
				head = '0;
				tail = '0;
			end else if (head == s) begin
				head = n;
			end else if (tail == s) begin
				tail = p;
			end else begin
				nxt[p] = n;
				prv[n] = p;
			end
		endfunction

		function void append(logic [ID_W-1:0] s);
			if (is_empty) begin
				head = s;
				tail = s;
				is_empty = 0;
			end else begin
				nxt[tail] = s;
				prv[s] = tail;
				tail = s;
			end
		endfunction

		function void timeout_walk(logic [47:0] now);
			logic [ID_W-1:0] s;
			logic [ID_W-1:0] shut_ids [32];
			logic [47:0]     seen;
			int              hits;
			int              step;
			bit              walk;
			s = head;
			hits = 0;
			walk = !is_empty;
			for (step = 0; walk && step < 32; step++) begin
				seen = stamp[s];
				if (now >= seen && (now - seen) > {16'd0, idle_limit}) begin
					if (!closing[s]) begin
						closing[s] = 1;
						shut_ids[hits] = s;
						hits++;
					end
				end else if (now < seen) begin
					stamp[s] = now;
				end else begin
					walk = 0;
				end
				if (walk) begin
					if (s == tail)
						walk = 0;
					else
						s = nxt[s];
				end
			end
			if (hits == 0)
				push_word('0, K_DONE, 1'b1);
			for (int i = 0; i < hits; i++)
				push_word(shut_ids[i], K_SHUTDOWN, i == hits - 1);
		endfunction

		// Predicts the words caused by one accepted request.
		function void apply_request(req_t req, logic [ID_W-1:0] id, logic [47:0] now);
			case (req)
				REQ_TICK: timeout_walk(now);
				REQ_OPEN: begin
					if (is_open[id]) begin
						push_word(id, K_ALREADY, 1'b1);
					end else begin
						is_open[id] = 1;
						closing[id] = 0;
						stamp[id] = now;
						append(id);
						push_word(id, K_DONE, 1'b1);
					end
				end
				default: begin
					if (!is_open[id]) begin
						push_word(id, K_NOT_OPEN, 1'b1);
					end else begin
						unlink(id);
						if (req == REQ_CLOSE) begin
							is_open[id] = 0;
							closing[id] = 0;
						end else begin
							stamp[id] = now;
							append(id);
						end
						push_word(id, K_DONE, 1'b1);
					end
				end
			endcase
		endfunction

		function void check_word(logic [ID_W-1:0] id, logic [1:0] kind, logic lst);
			word_t w;
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: id %0d kind %0d last %0d", $time, id, kind, lst);
				faults++;
				return;
			end
			w = pending_words.pop_front();
			if (id !== w.id) begin
				$display("%0t conn_id_res: expected %0d actual %0d", $time, w.id, id);
				faults++;
			end
			if (kind !== w.kind) begin
				$display("%0t result_kind: expected %0d actual %0d", $time, w.kind, kind);
				faults++;
			end
			if (lst !== w.lst) begin
				$display("%0t last: expected %0d actual %0d", $time, w.lst, lst);
				faults++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          req_type;
	logic [ID_W-1:0]     conn_id;
	logic [47:0]         event_time;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LIMIT_W-1:0]  cfg_data;
	logic                res_valid;
	logic [ID_W-1:0]     conn_id_res;
	logic [1:0]          result_kind;
	logic                last;

	conn_tracker tracker;
	logic [47:0] clock_us;

	idle_connection_lru_timeout dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.conn_id     (conn_id),
		.event_time  (event_time),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.res_valid   (res_valid),
		.conn_id_res (conn_id_res),
		.result_kind (result_kind),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid)
			tracker.check_word(conn_id_res, result_kind, last);
	end

	// Sends one request; entered and left at a rising edge.
	task automatic issue(input req_t req, input logic [ID_W-1:0] id, input logic [47:0] t,
			input bit steady);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		conn_id <= id;
		event_time <= t;
		do @(posedge clk); while (busy);
		tracker.apply_request(req, id, t);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		start <= 1'b0;
		while (tracker.pending_words.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.idle_limit = value;
	endtask

	task automatic random_phase(input int n, input bit steady);
		int              pick;
		req_t            req;
		logic [ID_W-1:0] id;
		logic [31:0]     lim;
		logic [31:0]     r_lo;
		logic [31:0]     r_hi;
		lim = tracker.idle_limit;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				req = REQ_OPEN;
			else if (pick < 45)
				req = REQ_CLOSE;
			else if (pick < 70)
				req = REQ_ACT;
			else
				req = REQ_TICK;
			id = ID_W'($urandom_range(0, 31));
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				clock_us = clock_us + 48'($urandom_range(0, lim / 8 + 2));
			end else if (pick < 85) begin
				r_lo = $urandom_range(0, lim);
				r_hi = $urandom_range(0, lim);
				clock_us = clock_us + 48'(r_lo) + 48'(r_hi);
			end else if (pick < 92) begin
				clock_us = clock_us - 48'($urandom_range(0, lim / 2 + 5));
			end else if (pick < 97) begin
				r_lo = $urandom;
				r_hi = $urandom;
				clock_us = {r_hi[15:0], r_lo};
			end else begin
				clock_us = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100));
			end
			issue(req, id, clock_us, steady);
		end
	endtask

	initial begin
		int w;
		tracker = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_OPEN;
		conn_id <= '0;
		event_time <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		clock_us = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, duplicates, boundaries, time jumps, unlink cases
		issue(REQ_TICK, 5'd31, 48'd0, 0);
		issue(REQ_OPEN, 5'd0, 48'd0, 0);
		issue(REQ_OPEN, 5'd31, 48'd5, 0);
		issue(REQ_OPEN, 5'd0, 48'd7, 0);
		issue(REQ_CLOSE, 5'd5, 48'd8, 0);
		issue(REQ_ACT, 5'd7, 48'd9, 0);
		issue(REQ_ACT, 5'd0, 48'd100, 0);
		issue(REQ_OPEN, 5'd16, 48'd200, 0);
		issue(REQ_TICK, 5'd0, 48'd10000005, 0);
		issue(REQ_TICK, 5'd0, 48'd10000006, 0);
		issue(REQ_TICK, 5'd21, 48'hFFFF_FFFF_FFFF, 0);
		issue(REQ_TICK, 5'd10, 48'hFFFF_FFFF_FFFF, 0);
		issue(REQ_OPEN, 5'd31, 48'd1, 0);
		issue(REQ_ACT, 5'd31, 48'hFFFF_FFFF_FFF0, 0);
		issue(REQ_TICK, 5'd0, 48'd50, 0);
		issue(REQ_CLOSE, 5'd16, 48'd60, 0);
		issue(REQ_CLOSE, 5'd0, 48'd61, 0);
		issue(REQ_CLOSE, 5'd31, 48'd62, 0);
		issue(REQ_CLOSE, 5'd31, 48'd63, 0);
		issue(REQ_OPEN, 5'd8, 48'd0, 0);
		issue(REQ_OPEN, 5'd9, 48'd0, 0);
		write_limit(32'd0);
		issue(REQ_TICK, 5'd0, 48'd0, 0);
		issue(REQ_TICK, 5'd0, 48'd1, 0);
		issue(REQ_CLOSE, 5'd9, 48'd2, 0);
		issue(REQ_ACT, 5'd8, 48'd3, 0);

		write_limit(32'd1000);
		random_phase(70, 0);
		write_limit(32'd0);
		random_phase(70, 1);
		write_limit(32'hFFFF_FFFF);
		random_phase(70, 0);
		write_limit($urandom_range(0, 50000));
		random_phase(70, 0);
		write_limit(LIMIT_RESET);
		random_phase(70, 0);
		start <= 1'b0;

		for (w = 0; w < 2000 && tracker.pending_words.size() != 0; w++) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
